// File: hdl/ehrd_pkg.sv
// Shared types and constants for the ECG heart-rate detector.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package ehrd_pkg;

    // Event codes carried on the result word's tuser
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_BPM   = 2'd2,
        EV_ZERO  = 2'd3
    } event_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RESET        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MINUTE = 2'd2;

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int WL_W     = 7;
    localparam int POS_W    = 6;
    localparam int TPM_W    = 24;
    localparam int CFG_W    = 24;

    // Reset values and limits
    localparam logic [WL_W-1:0]     WL_RESET   = 7'd40;
    localparam logic [WL_W-1:0]     WL_CAP     = 7'd64;
    localparam logic [SAMPLE_W-1:0] MINR_RESET = 8'd160;
    localparam logic [TPM_W-1:0]    TPM_RESET  = 24'd600000;
    localparam logic [POS_W-1:0]    POS_RESET  = 6'd1;

    // Serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = TPM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Packed word widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;

    // Controller to datapath commands
    typedef struct packed {
        logic item_take;   // input word accepted this edge
        logic div_step;    // one divider iteration
    } ehrd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;    // accepted word stops timing with a nonzero count
    } ehrd_status_t;

endpackage

`default_nettype wire

// File: hdl/ehrd_ctrl.sv
// Controller of the ECG heart-rate detector: handshakes and divider sequencing.
// Depends on ehrd_pkg for command/status types and divider step count.
`default_nettype none

module ehrd_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire ehrd_pkg::ehrd_status_t status,
    output ehrd_pkg::ehrd_cmd_t       cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    state_t                        state_reg, state_next;
    logic                          out_valid_reg, out_valid_next;
    logic [ehrd_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          take;

    // Take a word only when idle and the result slot is free or draining
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    assign cmd.item_take = take;
    assign cmd.div_step  = (state_reg == ST_DIVIDE);

    // Next-state logic
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        step_next      = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (out_valid_reg && m_tready) begin
                    out_valid_next = 1'b0;
                end
                if (take) begin
                    if (status.need_div) begin
                        state_next     = ST_DIVIDE;
                        step_next      = '0;
                        out_valid_next = 1'b0;
                    end else begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DIVIDE: begin
                step_next = step_reg + 1'b1;
                if (step_reg == ehrd_pkg::STEP_W'(ehrd_pkg::DIV_STEPS - 1)) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ehrd_datapath.sv
// Datapath of the ECG heart-rate detector: config registers, window tracking,
// crossing detection, interval counter and a restoring serial divider. Uses ehrd_pkg.
`default_nettype none

module ehrd_datapath #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [ehrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ehrd_pkg::CFG_W-1:0]        cfg_data,
    // input word fields
    input  wire logic                              in_mode,
    input  wire logic [ehrd_pkg::SAMPLE_W-1:0]     in_sample,
    // control
    input  wire ehrd_pkg::ehrd_cmd_t               cmd,
    output ehrd_pkg::ehrd_status_t                 status,
    // result fields
    output ehrd_pkg::event_t                       out_event,
    output logic [ehrd_pkg::TPM_W-1:0]             out_bpm,
    output logic [ehrd_pkg::SAMPLE_W-1:0]          out_threshold,
    output logic [ehrd_pkg::SAMPLE_W-1:0]          out_max,
    output logic [ehrd_pkg::SAMPLE_W-1:0]          out_min,
    output logic                                   out_saturated
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int SW = ehrd_pkg::SAMPLE_W;
    localparam int QW = ehrd_pkg::TPM_W;

    // Configuration registers
    logic [ehrd_pkg::WL_W-1:0]  wl_reg;
    logic [SW-1:0]              minr_reg;
    logic [QW-1:0]              tpm_reg;

    // Detector state
    logic [SW-1:0]                 prev_reg, prev_next;
    logic [ehrd_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [SW-1:0]                 max_reg, max_next;
    logic [SW-1:0]                 min_reg, min_next;
    logic [SW-1:0]                 thr_reg, thr_next;
    logic                          armed_reg, armed_next;
    logic [COUNT_WIDTH-1:0]        count_reg, count_next;
    logic                          counting_reg, counting_next;
    ehrd_pkg::event_t              event_reg, event_next;

    // Divider: quo_reg shifts dividend bits out and quotient bits in
    logic [QW-1:0]              quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0]     rem_reg, rem_next;
    logic [COUNT_WIDTH:0]       trial;
    logic [COUNT_WIDTH:0]       trial_diff;
    logic                       trial_ge;

    logic [ehrd_pkg::WL_W-1:0]  wl_cap;
    logic                       win_end;
    logic                       crossing;
    logic [SW:0]                mid_sum;

    // Window end test with the length capped
    assign wl_cap   = (wl_reg > ehrd_pkg::WL_CAP) ? ehrd_pkg::WL_CAP : wl_reg;
    assign win_end  = (wl_cap <= 7'd1) ||
                      ({1'b0, pos_reg} >= (wl_cap - 7'd1));
    assign crossing = (thr_reg != '0) && (prev_reg < thr_reg) && (in_sample > thr_reg);
    assign mid_sum  = {1'b0, max_reg} + {1'b0, min_reg};

    assign status.need_div = !in_mode && !win_end && crossing && armed_reg &&
                             (count_reg != '0);

    // Restoring divider step
    assign trial      = {rem_reg, quo_reg[QW-1]};
    assign trial_diff = trial - {1'b0, count_reg};
    assign trial_ge   = (trial >= {1'b0, count_reg});

    // Item update
    always_comb begin
        prev_next     = prev_reg;
        pos_next      = pos_reg;
        max_next      = max_reg;
        min_next      = min_reg;
        thr_next      = thr_reg;
        armed_next    = armed_reg;
        count_next    = count_reg;
        counting_next = counting_reg;
        event_next    = event_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        if (cmd.item_take) begin
            event_next = ehrd_pkg::EV_NONE;
            quo_next   = '0;
            if (in_mode) begin
                // timebase tick
                if (counting_reg && (count_reg != COUNT_MAX)) begin
                    count_next = count_reg + 1'b1;
                end
            end else begin
                prev_next = in_sample;
                if (win_end) begin
                    thr_next = mid_sum[SW:1];
                    max_next = '0;
                    min_next = minr_reg;
                    pos_next = ehrd_pkg::POS_RESET;
                end else begin
                    if (in_sample > max_reg) begin
                        max_next = in_sample;
                    end else if (in_sample < min_reg) begin
                        min_next = in_sample;
                    end
                    if (crossing) begin
                        if (!armed_reg) begin
                            armed_next    = 1'b1;
                            count_next    = '0;
                            counting_next = 1'b1;
                            event_next    = ehrd_pkg::EV_START;
                        end else begin
                            armed_next    = 1'b0;
                            counting_next = 1'b0;
                            if (count_reg == '0) begin
                                event_next = ehrd_pkg::EV_ZERO;
                            end else begin
                                event_next = ehrd_pkg::EV_BPM;
                                quo_next   = tpm_reg;
                                rem_next   = '0;
                            end
                        end
                    end
                    pos_next = pos_reg + 1'b1;
                end
            end
        end else if (cmd.div_step) begin
            quo_next = {quo_reg[QW-2:0], trial_ge};
            rem_next = trial_ge ? trial_diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg   <= ehrd_pkg::WL_RESET;
            minr_reg <= ehrd_pkg::MINR_RESET;
            tpm_reg  <= ehrd_pkg::TPM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                ehrd_pkg::CFG_WINDOW_LENGTH:    wl_reg   <= cfg_data[ehrd_pkg::WL_W-1:0];
                ehrd_pkg::CFG_MIN_RESET:        minr_reg <= cfg_data[SW-1:0];
                ehrd_pkg::CFG_TICKS_PER_MINUTE: tpm_reg  <= cfg_data[QW-1:0];
                default: ;
            endcase
        end
    end

    // Detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            pos_reg      <= ehrd_pkg::POS_RESET;
            max_reg      <= '0;
            min_reg      <= ehrd_pkg::MINR_RESET;
            thr_reg      <= '0;
            armed_reg    <= 1'b0;
            count_reg    <= '0;
            counting_reg <= 1'b0;
            event_reg    <= ehrd_pkg::EV_NONE;
        end else begin
            prev_reg     <= prev_next;
            pos_reg      <= pos_next;
            max_reg      <= max_next;
            min_reg      <= min_next;
            thr_reg      <= thr_next;
            armed_reg    <= armed_next;
            count_reg    <= count_next;
            counting_reg <= counting_next;
            event_reg    <= event_next;
        end
    end

    // Divider payload
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign out_event     = event_reg;
    assign out_bpm       = quo_reg;
    assign out_threshold = thr_reg;
    assign out_max       = max_reg;
    assign out_min       = min_reg;
    assign out_saturated = (count_reg == COUNT_MAX);

endmodule

`default_nettype wire

// File: hdl/ecg_heart_rate_detector_unit.sv
// Top level of the ECG heart-rate detector: stream ports, config port, and the
// wiring of ehrd_ctrl and ehrd_datapath. Uses ehrd_pkg.
//
// Takes one word per ECG sample or timebase tick (s_tuser selects) and gives one
// result word for each. For most words the result is shown the cycle after
// acceptance. A sample that ends an interval with a nonzero tick count starts
// the restoring serial divider (ticks_per_minute / count), one quotient bit per
// cycle, and its result is shown once the division ends. A new word is taken
// only while no division runs and the result register is empty or being read.
// Configuration writes are accepted every cycle and should be issued while idle.
`default_nettype none

module ecg_heart_rate_detector_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input words
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [ehrd_pkg::S_TDATA_W-1:0]       s_tdata,  // [7:0] sample
    input  wire logic                                 s_tuser,  // [0] mode
    // result words
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [23:0] bpm, [31:24] threshold, [39:32] window_max, [47:40] window_min,
    // [48] count_saturated, [55:49] zero
    output logic [ehrd_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic [1:0]                                m_tuser,  // [1:0] event_res
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ehrd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ehrd_pkg::CFG_W-1:0]           cfg_data
);

    ehrd_pkg::ehrd_cmd_t    cmd;
    ehrd_pkg::ehrd_status_t status;
    ehrd_pkg::event_t       out_event;
    logic [ehrd_pkg::TPM_W-1:0]    out_bpm;
    logic [ehrd_pkg::SAMPLE_W-1:0] out_threshold;
    logic [ehrd_pkg::SAMPLE_W-1:0] out_max;
    logic [ehrd_pkg::SAMPLE_W-1:0] out_min;
    logic                          out_saturated;

    assign cfg_ready = 1'b1;

    ehrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ehrd_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_mode       (s_tuser),
        .in_sample     (s_tdata[ehrd_pkg::SAMPLE_W-1:0]),
        .cmd           (cmd),
        .status        (status),
        .out_event     (out_event),
        .out_bpm       (out_bpm),
        .out_threshold (out_threshold),
        .out_max       (out_max),
        .out_min       (out_min),
        .out_saturated (out_saturated)
    );

    // Pack the result word
    assign m_tuser = out_event;
    assign m_tdata = {7'd0, out_saturated, out_min, out_max, out_threshold, out_bpm};

endmodule

`default_nettype wire

// File: hdl/ehrd_checker.sv
// Port-level checker for the ECG heart-rate detector, bound to the top level.
// Depends on ehrd_pkg for event codes.
`default_nettype none

module ehrd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result word changed while stalled");

    // No new word while an unread result is pending
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result pending");

    // bpm is zero unless the event is bpm ready
    a_bpm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ehrd_pkg::EV_BPM)) |-> (m_tdata[23:0] == 24'd0))
        else $error("bpm nonzero without bpm event");

    // A tick gives its result on the next cycle with no event
    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=>
            (m_tvalid && (m_tuser == ehrd_pkg::EV_NONE)))
        else $error("tick result missing");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ecg_heart_rate_detector_unit ehrd_checker u_ehrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
